// ----- design/cwc_pkg.sv -----
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the congestion window controller.
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int TIME_BITS   = 32;
   localparam int WINDOW_BITS = 10;
   localparam int COUNT_BITS  = 7;
   localparam int TMO_BITS    = 16;
   localparam int FUNC_BITS   = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [WINDOW_BITS-1:0] win_type;
   typedef logic [COUNT_BITS-1:0]  cnt_type;
   typedef logic [TIME_BITS-1:0]   tstamp_type;

   localparam win_type    RST_INIT_WINDOW = win_type'(10);
   localparam win_type    RST_INIT_THRESH = win_type'(64);
   localparam win_type    RST_WINDOW_CAP  = win_type'(200);
   localparam cnt_type    RST_BURST_LIMIT = cnt_type'(16);
   localparam logic [TMO_BITS-1:0] RST_LOSS_TMO = TMO_BITS'(50);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_START = 3'd0,
      FUNC_STOP  = 3'd1,
      FUNC_ACK   = 3'd2,
      FUNC_BURST = 3'd3,
      FUNC_WATCH = 3'd4
   } func_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INIT_WINDOW = 3'd0,
      CSR_INIT_THRESH = 3'd1,
      CSR_WINDOW_CAP  = 3'd2,
      CSR_BURST_LIMIT = 3'd3,
      CSR_LOSS_TMO    = 3'd4
   } csr_idx_type;

   typedef struct packed {
      win_type              init_window;
      win_type              init_thresh;
      win_type              window_cap;
      cnt_type              burst_limit;
      logic [TMO_BITS-1:0]  loss_tmo;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      tstamp_type           now_ms;
      cnt_type              send_room;
   } item_type;

   typedef struct packed {
      win_type window;
      win_type threshold;
      win_type in_flight;
      cnt_type sent_count;
      logic    loss_detected;
      logic    active;
   } result_type;

endpackage

// ----- design/cwc_csr.sv -----
// ----------------------------------------------------------------------------
// cwc_csr
// Configuration registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module cwc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [cwc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cwc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output cwc_pkg::cfg_type                  cfg
);

   cwc_pkg::cfg_type cfg_ff;
   cwc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (cwc_pkg::csr_idx_type'(csr_index))
            cwc_pkg::CSR_INIT_WINDOW:
               cfg_in.init_window = csr_wdata[cwc_pkg::WINDOW_BITS-1:0];
            cwc_pkg::CSR_INIT_THRESH:
               cfg_in.init_thresh = csr_wdata[cwc_pkg::WINDOW_BITS-1:0];
            cwc_pkg::CSR_WINDOW_CAP:
               cfg_in.window_cap = csr_wdata[cwc_pkg::WINDOW_BITS-1:0];
            cwc_pkg::CSR_BURST_LIMIT:
               cfg_in.burst_limit = csr_wdata[cwc_pkg::COUNT_BITS-1:0];
            cwc_pkg::CSR_LOSS_TMO:
               cfg_in.loss_tmo = csr_wdata[cwc_pkg::TMO_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_window <= cwc_pkg::RST_INIT_WINDOW;
         cfg_ff.init_thresh <= cwc_pkg::RST_INIT_THRESH;
         cfg_ff.window_cap  <= cwc_pkg::RST_WINDOW_CAP;
         cfg_ff.burst_limit <= cwc_pkg::RST_BURST_LIMIT;
         cfg_ff.loss_tmo    <= cwc_pkg::RST_LOSS_TMO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/cwc_engine.sv -----
// ----------------------------------------------------------------------------
// cwc_engine
// Controller state and its per-event update; the result reflects the state
// after the event.
// ----------------------------------------------------------------------------
module cwc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  cwc_pkg::item_type    item,
   input  cwc_pkg::cfg_type     cfg,
   output cwc_pkg::result_type  res
);

   logic                   running_ff, running_in;
   cwc_pkg::win_type       cwnd_ff, cwnd_in;
   cwc_pkg::win_type       ssthresh_ff, ssthresh_in;
   cwc_pkg::win_type       outstanding_ff, outstanding_in;
   cwc_pkg::win_type       acc_ff, acc_in;
   cwc_pkg::tstamp_type    last_ack_ff, last_ack_in;

   logic [cwc_pkg::WINDOW_BITS:0] grown;
   logic [cwc_pkg::WINDOW_BITS:0] acc_next;
   logic [cwc_pkg::WINDOW_BITS:0] capped;
   cwc_pkg::win_type       room;
   cwc_pkg::cnt_type       lim;
   cwc_pkg::cnt_type       sent;
   cwc_pkg::tstamp_type    elapsed;
   cwc_pkg::win_type       half;
   logic                   loss;

   always_comb begin
      running_in     = running_ff;
      cwnd_in        = cwnd_ff;
      ssthresh_in    = ssthresh_ff;
      outstanding_in = outstanding_ff;
      acc_in         = acc_ff;
      last_ack_in    = last_ack_ff;
      sent           = '0;
      loss           = 1'b0;
      grown          = {1'b0, cwnd_ff};
      acc_next       = {1'b0, acc_ff} + 1'b1;
      room           = (cwnd_ff > outstanding_ff) ? cwnd_ff - outstanding_ff : '0;
      lim            = (room > cwc_pkg::win_type'(cfg.burst_limit))
                       ? cfg.burst_limit : room[cwc_pkg::COUNT_BITS-1:0];
      elapsed        = item.now_ms - last_ack_ff;
      half           = cwnd_ff >> 1;

      if (cwnd_ff < ssthresh_ff) begin
         grown = {1'b0, cwnd_ff} + 1'b1;
      end else if (acc_next >= {1'b0, cwnd_ff}) begin
         grown    = {1'b0, cwnd_ff} + 1'b1;
         acc_next = '0;
      end
      capped = (grown > {1'b0, cfg.window_cap}) ? {1'b0, cfg.window_cap} : grown;

      case (cwc_pkg::func_type'(item.func))
         cwc_pkg::FUNC_START: begin
            running_in     = 1'b1;
            cwnd_in        = cfg.init_window;
            ssthresh_in    = cfg.init_thresh;
            outstanding_in = '0;
            acc_in         = '0;
            last_ack_in    = item.now_ms;
         end
         cwc_pkg::FUNC_STOP: begin
            running_in = 1'b0;
         end
         cwc_pkg::FUNC_ACK: begin
            if (running_ff) begin
               last_ack_in = item.now_ms;
               if (outstanding_ff != '0) begin
                  outstanding_in = outstanding_ff - 1'b1;
               end
               if (cwnd_ff >= ssthresh_ff) begin
                  acc_in = acc_next[cwc_pkg::WINDOW_BITS-1:0];
               end
               cwnd_in = capped[cwc_pkg::WINDOW_BITS-1:0];
            end
         end
         cwc_pkg::FUNC_BURST: begin
            if (running_ff) begin
               sent = (lim > item.send_room) ? item.send_room : lim;
               outstanding_in = outstanding_ff + cwc_pkg::win_type'(sent);
            end
         end
         cwc_pkg::FUNC_WATCH: begin
            if (running_ff && outstanding_ff != '0 &&
                elapsed > cwc_pkg::TIME_BITS'(cfg.loss_tmo)) begin
               loss           = 1'b1;
               ssthresh_in    = (half > cfg.init_window) ? half : cfg.init_window;
               cwnd_in        = cfg.init_window;
               outstanding_in = '0;
               last_ack_in    = item.now_ms;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         cwnd_ff        <= cwc_pkg::RST_INIT_WINDOW;
         ssthresh_ff    <= cwc_pkg::RST_INIT_THRESH;
         outstanding_ff <= '0;
         acc_ff         <= '0;
         last_ack_ff    <= '0;
      end else if (fire) begin
         running_ff     <= running_in;
         cwnd_ff        <= cwnd_in;
         ssthresh_ff    <= ssthresh_in;
         outstanding_ff <= outstanding_in;
         acc_ff         <= acc_in;
         last_ack_ff    <= last_ack_in;
      end
   end

   assign res.window        = cwnd_in;
   assign res.threshold     = ssthresh_in;
   assign res.in_flight     = outstanding_in;
   assign res.sent_count    = sent;
   assign res.loss_detected = loss;
   assign res.active        = running_in;

   a_sent_only_burst: assert property (@(posedge clock) disable iff (reset)
      fire && item.func != cwc_pkg::FUNC_BURST |-> res.sent_count == '0)
      else $error("sent_count nonzero outside a burst");

   a_loss_clears: assert property (@(posedge clock) disable iff (reset)
      fire && res.loss_detected |=> outstanding_ff == '0 && cwnd_ff == $past(cfg.init_window))
      else $error("loss did not reset window and in-flight");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      fire && !running_ff && (item.func == cwc_pkg::FUNC_ACK ||
      item.func == cwc_pkg::FUNC_BURST || item.func == cwc_pkg::FUNC_WATCH)
      |=> $stable(cwnd_ff) && $stable(outstanding_ff) && $stable(ssthresh_ff))
      else $error("state changed while stopped");

endmodule

// ----- design/congestion_window_controller_top.sv -----
// ----------------------------------------------------------------------------
// congestion_window_controller_top
// Packet-counting congestion window controller with valid/ready channels.
// ----------------------------------------------------------------------------
// One event per clock while the output register can drain. An event accepted
// at a clock edge is held in the input register until it is applied to the
// controller state, in a cycle in which the output register is empty or its
// result is taken; the result of the event is then loaded into the output
// register, which drives rsp_valid. Input and output registers decouple the
// channels; the input keeps accepting while a result waits as long as the
// output register can drain. Configuration writes take effect on the next
// cycle and should only be issued while no event is pending.
module congestion_window_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cwc_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [cwc_pkg::TIME_BITS-1:0]      req_now_ms,
   input  logic [cwc_pkg::COUNT_BITS-1:0]     req_send_room,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cwc_pkg::WINDOW_BITS-1:0]    rsp_window,
   output logic [cwc_pkg::WINDOW_BITS-1:0]    rsp_threshold,
   output logic [cwc_pkg::WINDOW_BITS-1:0]    rsp_in_flight,
   output logic [cwc_pkg::COUNT_BITS-1:0]     rsp_sent_count,
   output logic                               rsp_loss_detected,
   output logic                               rsp_active,
   input  logic                               csr_write_en,
   input  logic [cwc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cwc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   cwc_pkg::item_type    in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   cwc_pkg::result_type  out_res_ff;
   cwc_pkg::result_type  res;
   cwc_pkg::cfg_type     cfg;
   logic                 advance;
   logic                 req_xfer;

   cwc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   cwc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.func      <= req_func;
         in_item_ff.now_ms    <= req_now_ms;
         in_item_ff.send_room <= req_send_room;
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_window        = out_res_ff.window;
   assign rsp_threshold     = out_res_ff.threshold;
   assign rsp_in_flight     = out_res_ff.in_flight;
   assign rsp_sent_count    = out_res_ff.sent_count;
   assign rsp_loss_detected = out_res_ff.loss_detected;
   assign rsp_active        = out_res_ff.active;

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("applied event produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !advance)
      else $error("pending result overwritten");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held event lost");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for congestion_window_controller_top. A table of
// directed events covers the idle-state cases, start and restart, burst
// limits, slow start, congestion avoidance and watchdog timeouts across the
// time wrap. Random phases follow, each under its own register setting and
// handshake pacing. Every accepted event runs through a local model of the
// window state, and each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cwc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 200;
   localparam int NUM_PHASES  = 8;
   localparam int NUM_ROWS    = 24;

   localparam logic [FUNC_BITS-1:0] FUNC_SPARE5 = 3'd5;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE7 = 3'd7;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      tstamp_type           now_ms;
      cnt_type              room;
      logic                 typed;
      result_type           want;
   } event_row_type;

   // typed rows assume the reset register values
   localparam event_row_type EVENT_TABLE [NUM_ROWS] = '{
      '{FUNC_ACK,    32'd0,          7'd0,  1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b0}},
      '{FUNC_BURST,  32'd0,          7'd64, 1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b0}},
      '{FUNC_WATCH,  32'hFFFFFFFF,   7'd0,  1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b0}},
      '{FUNC_SPARE5, 32'd7,          7'd0,  1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b0}},
      '{FUNC_SPARE7, 32'd9,          7'd64, 1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b0}},
      '{FUNC_START,  32'd100,        7'd0,  1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b1}},
      '{FUNC_BURST,  32'd100,        7'd64, 1'b1, '{10'd10, 10'd64, 10'd10, 7'd10, 1'b0, 1'b1}},
      '{FUNC_BURST,  32'd101,        7'd64, 1'b1, '{10'd10, 10'd64, 10'd10, 7'd0, 1'b0, 1'b1}},
      '{FUNC_ACK,    32'd105,        7'd0,  1'b1, '{10'd11, 10'd64, 10'd9, 7'd0,  1'b0, 1'b1}},
      '{FUNC_WATCH,  32'd155,        7'd0,  1'b1, '{10'd11, 10'd64, 10'd9, 7'd0,  1'b0, 1'b1}},
      '{FUNC_WATCH,  32'd156,        7'd0,  1'b1, '{10'd10, 10'd10, 10'd0, 7'd0,  1'b1, 1'b1}},
      '{FUNC_ACK,    32'd160,        7'd0,  1'b1, '{10'd10, 10'd10, 10'd0, 7'd0,  1'b0, 1'b1}},
      '{FUNC_WATCH,  32'd1000,       7'd0,  1'b0, '0},
      '{FUNC_BURST,  32'd1001,       7'd3,  1'b0, '0},
      '{FUNC_SPARE6, 32'd1002,       7'd64, 1'b0, '0},
      '{FUNC_STOP,   32'd1003,       7'd0,  1'b0, '0},
      '{FUNC_ACK,    32'd1004,       7'd0,  1'b0, '0},
      '{FUNC_START,  32'hFFFFFFF0,   7'd0,  1'b1, '{10'd10, 10'd64, 10'd0, 7'd0,  1'b0, 1'b1}},
      '{FUNC_START,  32'hFFFFFFF8,   7'd0,  1'b0, '0},
      '{FUNC_BURST,  32'hFFFFFFFA,   7'd64, 1'b0, '0},
      '{FUNC_WATCH,  32'h0000002A,   7'd0,  1'b0, '0},
      '{FUNC_WATCH,  32'h0000002B,   7'd0,  1'b0, '0},
      '{FUNC_BURST,  32'h0000002C,   7'd63, 1'b0, '0},
      '{FUNC_STOP,   32'hFFFFFFFF,   7'd0,  1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [FUNC_BITS-1:0]     req_func;
   tstamp_type               req_now_ms;
   cnt_type                  req_send_room;
   logic                     rsp_valid;
   logic                     rsp_ready;
   win_type                  rsp_window;
   win_type                  rsp_threshold;
   win_type                  rsp_in_flight;
   cnt_type                  rsp_sent_count;
   logic                     rsp_loss_detected;
   logic                     rsp_active;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // expectation attached to the event currently offered
   logic       drv_typed;
   result_type drv_want;

   // window state as the block should hold it
   cfg_type    cfg_shadow;
   logic       run_flag;
   win_type    cwnd;
   win_type    ssthresh;
   win_type    unacked;
   win_type    ack_count;
   tstamp_type last_ack_ms;

   result_type expected_status_q[$];
   int         mismatch_count;
   int         cycle_count;
   int         send_idle_pct;
   int         recv_stall_pct;
   tstamp_type stim_clock_ms;
   tstamp_type stim_ack_ms;

   congestion_window_controller_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_now_ms        (req_now_ms),
      .req_send_room     (req_send_room),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_window        (rsp_window),
      .rsp_threshold     (rsp_threshold),
      .rsp_in_flight     (rsp_in_flight),
      .rsp_sent_count    (rsp_sent_count),
      .rsp_loss_detected (rsp_loss_detected),
      .rsp_active        (rsp_active),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic result_type advance_window(logic [FUNC_BITS-1:0] fn, tstamp_type now,
                                                 cnt_type room_in);
      result_type  r;
      int unsigned w;
      int unsigned acc;
      int unsigned room;
      int unsigned sent;
      int unsigned half;
      tstamp_type  elapsed;
      logic        loss;
      sent = 0;
      loss = 1'b0;
      if (fn == FUNC_START) begin
         run_flag    = 1'b1;
         cwnd        = cfg_shadow.init_window;
         ssthresh    = cfg_shadow.init_thresh;
         unacked     = '0;
         ack_count   = '0;
         last_ack_ms = now;
      end else if (fn == FUNC_STOP) begin
         run_flag = 1'b0;
      end else if (fn == FUNC_ACK && run_flag) begin
         w = cwnd;
         last_ack_ms = now;
         if (unacked != 0) unacked = unacked - 1'b1;
         if (w < ssthresh) begin
            w = w + 1;
         end else begin
            acc = ack_count + 1;
            if (acc >= w) begin
               w = w + 1;
               acc = 0;
            end
            ack_count = win_type'(acc);
         end
         cwnd = win_type'((w < cfg_shadow.window_cap) ? w : cfg_shadow.window_cap);
      end else if (fn == FUNC_BURST && run_flag) begin
         room = (cwnd > unacked) ? cwnd - unacked : 0;
         sent = (room < cfg_shadow.burst_limit) ? room : cfg_shadow.burst_limit;
         if (room_in < sent) sent = room_in;
         unacked = win_type'(unacked + sent);
      end else if (fn == FUNC_WATCH && run_flag) begin
         elapsed = now - last_ack_ms;
         if (unacked != 0 && elapsed > cfg_shadow.loss_tmo) begin
            half        = cwnd >> 1;
            ssthresh    = win_type'((half > cfg_shadow.init_window) ?
                                    half : cfg_shadow.init_window);
            cwnd        = cfg_shadow.init_window;
            unacked     = '0;
            last_ack_ms = now;
            loss        = 1'b1;
         end
      end
      r.window        = cwnd;
      r.threshold     = ssthresh;
      r.in_flight     = unacked;
      r.sent_count    = cnt_type'(sent);
      r.loss_detected = loss;
      r.active        = run_flag;
      return r;
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      cfg_shadow.init_window = RST_INIT_WINDOW;
      cfg_shadow.init_thresh = RST_INIT_THRESH;
      cfg_shadow.window_cap  = RST_WINDOW_CAP;
      cfg_shadow.burst_limit = RST_BURST_LIMIT;
      cfg_shadow.loss_tmo    = RST_LOSS_TMO;
      run_flag       = 1'b0;
      cwnd           = RST_INIT_WINDOW;
      ssthresh       = RST_INIT_THRESH;
      unacked        = '0;
      ack_count      = '0;
      last_ack_ms    = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   end

   // result check first, then prediction of the transfer taken on this edge
   always @(posedge clock) begin
      result_type want;
      result_type model;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual %0d/%0d/%0d/%0d/%0d/%0d",
                        $time, rsp_window, rsp_threshold, rsp_in_flight, rsp_sent_count,
                        rsp_loss_detected, rsp_active);
               mismatch_count++;
            end else begin
               want = expected_status_q.pop_front();
               compare_field("window", want.window, rsp_window);
               compare_field("threshold", want.threshold, rsp_threshold);
               compare_field("in_flight", want.in_flight, rsp_in_flight);
               compare_field("sent_count", want.sent_count, rsp_sent_count);
               compare_field("loss_detected", want.loss_detected, rsp_loss_detected);
               compare_field("active", want.active, rsp_active);
            end
         end
         if (req_valid && req_ready) begin
            model = advance_window(req_func, req_now_ms, req_send_room);
            expected_status_q.insert(expected_status_q.size(), drv_typed ? drv_want : model);
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_INIT_WINDOW: cfg_shadow.init_window = csr_wdata[WINDOW_BITS-1:0];
               CSR_INIT_THRESH: cfg_shadow.init_thresh = csr_wdata[WINDOW_BITS-1:0];
               CSR_WINDOW_CAP:  cfg_shadow.window_cap  = csr_wdata[WINDOW_BITS-1:0];
               CSR_BURST_LIMIT: cfg_shadow.burst_limit = csr_wdata[COUNT_BITS-1:0];
               CSR_LOSS_TMO:    cfg_shadow.loss_tmo    = csr_wdata[TMO_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_event(logic [FUNC_BITS-1:0] fn, tstamp_type now, cnt_type room,
                             logic typed, result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_now_ms    <= now;
      req_send_room <= room;
      drv_typed     <= typed;
      drv_want      <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain(int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= CSR_DATA_BITS'(value);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned          iw;
      int unsigned          ith;
      int unsigned          cap;
      int unsigned          bl;
      int unsigned          tmo;
      int unsigned          pick;
      logic [FUNC_BITS-1:0] fn;
      tstamp_type           now;
      cnt_type              room;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_STOP;
      req_now_ms    <= '0;
      req_send_room <= '0;
      rsp_ready     <= 1'b0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_INIT_WINDOW;
      csr_wdata     <= '0;
      drv_typed     <= 1'b0;
      drv_want      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_event(EVENT_TABLE[i].func, EVENT_TABLE[i].now_ms, EVENT_TABLE[i].room,
                    EVENT_TABLE[i].typed, EVENT_TABLE[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain(4);
         case (p)
            0: begin iw = 10;   ith = 64;   cap = 200;  bl = 16; tmo = 50;    end
            1: begin iw = 1;    ith = 1;    cap = 1023; bl = 64; tmo = 1;     end
            2: begin iw = 1023; ith = 1023; cap = 1023; bl = 64; tmo = 65535; end
            3: begin iw = 1;    ith = 1023; cap = 1;    bl = 1;  tmo = 1;     end
            6: begin iw = 2;    ith = 3;    cap = 20;   bl = 4;  tmo = 10;    end
            default: begin
               iw  = $urandom_range(1, 1023);
               ith = $urandom_range(1, 1023);
               cap = $urandom_range(1, 1023);
               bl  = $urandom_range(1, 64);
               tmo = $urandom_range(1, 65535);
            end
         endcase
         write_csr(CSR_INIT_WINDOW, iw);
         write_csr(CSR_INIT_THRESH, ith);
         write_csr(CSR_WINDOW_CAP, cap);
         write_csr(CSR_BURST_LIMIT, bl);
         write_csr(CSR_LOSS_TMO, tmo);
         csr_write_en <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         stim_clock_ms = 32'hFFFFFFFF - $urandom_range(0, 5000);
         stim_ack_ms   = stim_clock_ms;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) stim_clock_ms += $urandom_range(0, 2 * tmo);
            stim_clock_ms += $urandom_range(0, 3);
            now  = stim_clock_ms;
            room = ($urandom_range(0, 3) == 0) ? cnt_type'(64) : cnt_type'($urandom_range(0, 64));
            if (pick < 3) begin
               fn = FUNC_START;
               stim_ack_ms = now;
            end else if (pick < 5) begin
               fn = FUNC_STOP;
            end else if (pick < 50) begin
               fn = FUNC_ACK;
               stim_ack_ms = now;
            end else if (pick < 80) begin
               fn = FUNC_BURST;
            end else if (pick < 95) begin
               fn = FUNC_WATCH;
               // aim at the timeout boundary half of the time
               if ($urandom_range(0, 1)) begin
                  now = stim_ack_ms + tmo + $urandom_range(0, 2) - 1;
                  stim_clock_ms = now;
                  stim_ack_ms   = now;
               end
            end else begin
               fn = FUNC_BITS'($urandom_range(5, 7));
               now = $urandom();
            end
            send_event(fn, now, room, 1'b0, '0);
         end
      end

      drain(8);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
